### rtl/svtl_pkg.sv
// ----------------------------------------------------------------------------
// svtl_pkg - supply voltage trim loop shared definitions
// Field widths, loop constants, register indexes and the DAC remap function.
// ----------------------------------------------------------------------------
package svtl_pkg;

   // item kinds
   localparam logic KIND_SET  = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // configuration register indexes
   localparam int  CsrIdxW = 2;
   localparam int  CsrDataW = 8;
   localparam logic [CsrIdxW-1:0] CSR_BAND  = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_DELAY = 2'd1;

   localparam int NumModulesDef = 2;

   localparam int SetW   = 16;
   localparam int MeasW  = 15;
   localparam int TgtW   = 12;
   localparam int CodeW  = 8;
   localparam int BandW  = 8;
   localparam int DelayW = 4;

   localparam int ReqDataW = 40;
   localparam int RspDataW = 24;

   localparam logic [SetW-1:0]   MvMin       = 16'd1220;
   localparam logic [SetW-1:0]   MvMax       = 16'd4020;
   localparam logic [CodeW-1:0]  CodeUpLimit = 8'd254;
   localparam logic [CodeW-1:0]  CodeDnLimit = 8'd1;
   localparam logic [CodeW-1:0]  DacMid      = 8'd128;
   localparam logic [BandW-1:0]  BandReset   = 8'd30;
   localparam logic [DelayW-1:0] DelayReset  = 4'd3;

   // code = delta*255/2800 as (delta*CodeRecip) >> CodeShift, exact for delta <= 2800
   localparam int CodeShift = 23;
   localparam int RecipW    = 20;
   localparam logic [RecipW-1:0] CodeRecip = 20'd763963;
   localparam int ProdW     = TgtW + RecipW;

   // step s goes out as s-128 at or above mid scale, else as 255-s
   function automatic logic [CodeW-1:0] dac_remap(input logic [CodeW-1:0] s);
      dac_remap = (s >= DacMid) ? (s - DacMid) : ~s;
   endfunction

endpackage

### rtl/supply_voltage_trim_loop_unit.sv
// ----------------------------------------------------------------------------
// supply_voltage_trim_loop_unit - per-module output voltage trim loop
// Set beats load a target and initial trim code, tick beats step the code
// toward the measured target and issue remapped DAC bytes.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  req     | in  | req_tvalid/tready   | tuser kind, tdata item fields
//  rsp     | out | rsp_tvalid/tready   | tdata result fields
//  csr     | in  | csr_valid/ready     | csr_index, csr_data
//
// One beat per cycle sustained while rsp is not stalled; a request beat passes
// through the input register, then the result register where module state is
// updated, before its result is offered. Reset (synchronous, active high)
// clears valid flags and module state; delays and config load reset values.
// A stalled rsp holds the result register; req backs up only when both the
// input and result registers are full. csr is always ready.
module supply_voltage_trim_loop_unit #(
   parameter int NUM_MODULES = svtl_pkg::NumModulesDef
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic                          req_tuser,   // kind
   // [0] module_req, [16:1] set_mv, [31:17] measured_mv, [32] dac_write_ok
   input  logic [svtl_pkg::ReqDataW-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [0] dac_write, [8:1] dac_byte, [9] supply_enable, [10] regulated,
   // [18:11] trim_code
   output logic [svtl_pkg::RspDataW-1:0] rsp_tdata,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [svtl_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [svtl_pkg::CsrDataW-1:0] csr_data
);
   import svtl_pkg::*;

   localparam int IdxW = (NUM_MODULES > 1) ? $clog2(NUM_MODULES) : 1;

   // configuration
   logic [BandW-1:0]  band_ff;
   logic [DelayW-1:0] start_dly_ff;

   // input register
   logic             s1_valid_ff;
   logic             s1_kind_ff;
   logic             s1_mod_ff;
   logic [SetW-1:0]  s1_set_ff;
   logic [MeasW-1:0] s1_meas_ff;
   logic             s1_ok_ff;

   // module state
   logic              on_ff   [NUM_MODULES];
   logic [CodeW-1:0]  code_ff [NUM_MODULES];
   logic [TgtW-1:0]   tgt_ff  [NUM_MODULES];
   logic              good_ff [NUM_MODULES];
   logic [DelayW-1:0] dly_ff  [NUM_MODULES];
   logic              en_ff;

   // result register
   logic                rsp_valid_ff;
   logic [RspDataW-1:0] rsp_data_ff;

   logic move;
   logic in_range;
   logic [IdxW-1:0] idx;

   logic              on_cur, good_cur;
   logic [CodeW-1:0]  code_cur;
   logic [TgtW-1:0]   tgt_cur;
   logic [DelayW-1:0] dly_cur;

   logic              on_in, good_in, en_in, wr;
   logic [CodeW-1:0]  code_in, step, dac_byte;
   logic [TgtW-1:0]   tgt_in;
   logic [DelayW-1:0] dly_in;

   logic [SetW-1:0]  set_clamp;
   logic [TgtW-1:0]  delta;
   logic [ProdW-1:0] prod;
   logic [MeasW-1:0] meas_hi;
   logic [RspDataW-1:0] rsp_data_in;

   assign move       = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || move;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign in_range = 32'(s1_mod_ff) < NUM_MODULES;
   assign idx      = IdxW'(s1_mod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff      <= BandReset;
         start_dly_ff <= DelayReset;
      end else if (csr_valid) begin
         if (csr_index == CSR_BAND) begin
            band_ff <= csr_data;
         end else if (csr_index == CSR_DELAY) begin
            start_dly_ff <= csr_data[DelayW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         s1_kind_ff <= req_tuser;
         s1_mod_ff  <= req_tdata[0];
         s1_set_ff  <= req_tdata[16:1];
         s1_meas_ff <= req_tdata[31:17];
         s1_ok_ff   <= req_tdata[32];
      end
   end

   always_comb begin
      if (in_range) begin
         on_cur   = on_ff[idx];
         good_cur = good_ff[idx];
         code_cur = code_ff[idx];
         tgt_cur  = tgt_ff[idx];
         dly_cur  = dly_ff[idx];
      end else begin
         on_cur   = 1'b0;
         good_cur = 1'b0;
         code_cur = '0;
         tgt_cur  = '0;
         dly_cur  = '0;
      end
   end

   // initial trim code from the clamped target
   assign set_clamp = (s1_set_ff > MvMax) ? MvMax : s1_set_ff;
   assign delta     = TgtW'(set_clamp - MvMin);
   assign prod      = ProdW'(delta) * ProdW'(CodeRecip);
   assign meas_hi   = MeasW'(tgt_cur) + MeasW'(band_ff);

   always_comb begin
      on_in   = on_cur;
      good_in = good_cur;
      code_in = code_cur;
      tgt_in  = tgt_cur;
      dly_in  = dly_cur;
      en_in   = en_ff;
      wr      = 1'b0;
      step    = '0;
      if (s1_kind_ff == KIND_SET) begin
         if (s1_set_ff < MvMin) begin
            en_in   = 1'b0;
            on_in   = 1'b0;
            code_in = '0;
            tgt_in  = '0;
            good_in = 1'b0;
            dly_in  = start_dly_ff;
         end else begin
            on_in   = 1'b1;
            tgt_in  = TgtW'(set_clamp);
            code_in = prod[CodeShift +: CodeW];
         end
      end else if (!on_cur) begin
         good_in = 1'b0;
      end else if (dly_cur != '0) begin
         dly_in = dly_cur - DelayW'(1);
         if (dly_cur == DelayW'(1)) begin
            en_in = 1'b1;
         end
      end else begin
         priority if (s1_meas_ff < MeasW'(tgt_cur)) begin
            if (code_cur < CodeUpLimit) begin
               step = code_cur + CodeW'(1);
               wr   = 1'b1;
            end
         end else if (s1_meas_ff > meas_hi) begin
            if (code_cur > CodeDnLimit) begin
               step = code_cur - CodeW'(1);
               wr   = 1'b1;
            end
         end else begin
            good_in = 1'b1;
         end
         if (wr && s1_ok_ff) begin
            code_in = step;
         end
      end
   end

   assign dac_byte = wr ? dac_remap(step) : '0;

   always_comb begin
      rsp_data_in = '0;
      if (in_range) begin
         rsp_data_in[0]     = wr;
         rsp_data_in[8:1]   = dac_byte;
         rsp_data_in[9]     = en_in;
         rsp_data_in[10]    = good_in;
         rsp_data_in[18:11] = code_in;
      end else begin
         rsp_data_in[9] = en_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_MODULES; i++) begin
            on_ff[i]   <= 1'b0;
            code_ff[i] <= '0;
            tgt_ff[i]  <= '0;
            good_ff[i] <= 1'b0;
            dly_ff[i]  <= DelayReset;
         end
         en_ff <= 1'b0;
      end else if (move && in_range) begin
         on_ff[idx]   <= on_in;
         code_ff[idx] <= code_in;
         tgt_ff[idx]  <= tgt_in;
         good_ff[idx] <= good_in;
         dly_ff[idx]  <= dly_in;
         en_ff        <= en_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

### rtl/svtl_checker.sv
// ----------------------------------------------------------------------------
// svtl_checker - port level checks for the supply voltage trim loop
// Watches the result channel for stall behavior and payload consistency.
// ----------------------------------------------------------------------------
module svtl_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [svtl_pkg::RspDataW-1:0] rsp_tdata
);
   import svtl_pkg::*;

   // a stalled result beat stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed under stall");

   // no DAC byte without a write
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[8:1] == '0)
      else $error("dac_byte nonzero without dac_write");

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind supply_voltage_trim_loop_unit svtl_checker u_svtl_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### test/tb.sv
// ----------------------------------------------------------------------------
// tb - supply voltage trim loop unit testbench
// Drives set and tick beats into the trim loop, predicts every result beat
// from a behavioral copy of the per-module trim state, and checks each result
// field by field. Runs a directed pass over the limits, then random target
// and measurement sequences under several band and start delay settings,
// with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb;
   import svtl_pkg::*;

   localparam int NumMods = NumModulesDef;
   localparam logic [CsrIdxW-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_SPARE_HI = 2'd3;
   localparam int LongHold = 200;
   localparam int SettleCycles = 4;
   localparam int MaxReports = 40;

   typedef struct packed {
      logic             dac_write;
      logic [CodeW-1:0] dac_byte;
      logic             supply_enable;
      logic             regulated;
      logic [CodeW-1:0] trim_code;
   } trim_result_type;

   class trim_loop_scoreboard;
      logic              module_on   [NumMods];
      logic [CodeW-1:0]  code_store  [NumMods];
      int                target_mv   [NumMods];
      logic              good_flag   [NumMods];
      logic [DelayW-1:0] delay_left  [NumMods];
      logic              enable_pin;
      logic [BandW-1:0]  band_mv;
      logic [DelayW-1:0] start_delay;
      trim_result_type   expected_results[$];
      int                errors;

      function new();
         for (int i = 0; i < NumMods; i++) begin
            module_on[i]  = 1'b0;
            code_store[i] = '0;
            target_mv[i]  = 0;
            good_flag[i]  = 1'b0;
            delay_left[i] = DelayReset;
         end
         enable_pin  = 1'b0;
         band_mv     = BandReset;
         start_delay = DelayReset;
         errors      = 0;
      endfunction

      function void write_reg(logic [CsrIdxW-1:0] idx, logic [CsrDataW-1:0] val);
         case (idx)
            CSR_BAND:  band_mv = val[BandW-1:0];
            CSR_DELAY: start_delay = val[DelayW-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // advance the trim state by one accepted request beat
      function void note_request(logic kind, logic m, logic [SetW-1:0] set_mv,
                                 logic [MeasW-1:0] meas, logic ok);
         trim_result_type r;
         int tgt;
         int step;
         int mv_lo;
         int mv_hi;
         r = '0;
         step = 0;
         mv_lo = MvMin;
         mv_hi = MvMax;
         if (int'(m) >= NumMods) begin
            r.supply_enable = enable_pin;
            expected_results.push_back(r);
            return;
         end
         if (kind == KIND_SET) begin
            if (set_mv < MvMin) begin
               enable_pin    = 1'b0;
               module_on[m]  = 1'b0;
               code_store[m] = '0;
               target_mv[m]  = 0;
               good_flag[m]  = 1'b0;
               delay_left[m] = start_delay;
            end else begin
               tgt = (set_mv > MvMax) ? mv_hi : int'(set_mv);
               target_mv[m]  = tgt;
               module_on[m]  = 1'b1;
               code_store[m] = CodeW'(((tgt - mv_lo) * 255) / (mv_hi - mv_lo));
            end
         end else if (!module_on[m]) begin
            good_flag[m] = 1'b0;
         end else if (delay_left[m] != 0) begin
            delay_left[m] = delay_left[m] - DelayW'(1);
            if (delay_left[m] == 0) enable_pin = 1'b1;
         end else begin
            tgt = target_mv[m];
            if (int'(meas) < tgt) begin
               if (code_store[m] < CodeUpLimit) begin
                  step = int'(code_store[m]) + 1;
                  r.dac_write = 1'b1;
               end
            end else if (int'(meas) > tgt + int'(band_mv)) begin
               if (code_store[m] > CodeDnLimit) begin
                  step = int'(code_store[m]) - 1;
                  r.dac_write = 1'b1;
               end
            end else begin
               good_flag[m] = 1'b1;
            end
            if (r.dac_write) begin
               r.dac_byte = (step >= int'(DacMid)) ? CodeW'(step - int'(DacMid))
                                                   : CodeW'(255 - step);
               if (ok) code_store[m] = CodeW'(step);
            end
         end
         r.supply_enable = enable_pin;
         r.regulated     = good_flag[m];
         r.trim_code     = code_store[m];
         expected_results.push_back(r);
      endfunction

      function void compare(string field, int want, int got);
         if (want != got) begin
            errors++;
            if (errors <= MaxReports)
               $display("%0t: %s mismatch expected %0d actual %0d", $time, field, want, got);
         end
      endfunction

      function void check_result(logic [RspDataW-1:0] word);
         trim_result_type want;
         if (expected_results.size() == 0) begin
            errors++;
            if (errors <= MaxReports)
               $display("%0t: unexpected result beat expected none actual %h", $time, word);
            return;
         end
         want = expected_results.pop_front();
         compare("dac_write", want.dac_write, word[0]);
         compare("dac_byte", want.dac_byte, word[8:1]);
         compare("supply_enable", want.supply_enable, word[9]);
         compare("regulated", want.regulated, word[10]);
         compare("trim_code", want.trim_code, word[18:11]);
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic                req_tuser = 1'b0;
   logic [ReqDataW-1:0] req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b1;
   logic [RspDataW-1:0] rsp_tdata;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [CsrDataW-1:0] csr_data = '0;

   trim_loop_scoreboard sb = new();
   bit calm = 1'b0;
   bit hold_rsp = 1'b0;
   int sender_quiet = 0;

   supply_voltage_trim_loop_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #(20 * 500000);
      $display("status: fail");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // result side: random stall bursts, quiet stretches, one long hold-off
   initial begin
      int quiet;
      bit held;
      quiet = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LongHold) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (calm || quiet > 0) begin
            if (quiet > 0) quiet--;
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 24) == 0) begin
            quiet = $urandom_range(20, 60);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // valid stays high on return; the caller decides whether to drop it
   task automatic send_item(input logic kind, input logic m, input logic [SetW-1:0] set_mv,
                            input logic [MeasW-1:0] meas, input logic ok);
      logic [ReqDataW-1:0] beat;
      beat = '0;
      beat[0] = m;
      beat[SetW:1] = set_mv;
      beat[SetW+MeasW:SetW+1] = meas;
      beat[SetW+MeasW+1] = ok;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= beat;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(kind, m, set_mv, meas, ok);
   endtask

   task automatic sender_gap();
      if (calm) return;
      if (sender_quiet > 0) begin
         sender_quiet--;
      end else if ($urandom_range(0, 19) == 0) begin
         sender_quiet = $urandom_range(10, 40);
      end else if ($urandom_range(0, 2) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   // spare index goes last so a bad decode would clobber a live register
   task automatic configure(input logic [BandW-1:0] band, input logic [DelayW-1:0] dly);
      csr_write(CSR_BAND, band);
      csr_write(CSR_DELAY, {(CsrDataW-DelayW)'($urandom), dly});
      csr_write($urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO, CsrDataW'($urandom));
      csr_valid <= 1'b0;
      repeat (2) @(posedge clock);
   endtask

   // mostly a target followed by a run of ticks around it, some noise beats
   task automatic run_trim_phase(input int n_items);
      int done_items;
      int pick;
      int tgt;
      int meas;
      logic m;
      logic tick_m;
      logic [SetW-1:0] set_mv;
      done_items = 0;
      while (done_items < n_items) begin
         m = 1'($urandom);
         if ($urandom_range(0, 9) == 0) begin
            send_item(1'($urandom), m, SetW'($urandom), MeasW'($urandom), 1'($urandom));
            done_items++;
            sender_gap();
         end else begin
            pick = $urandom_range(0, 9);
            if (pick == 0) set_mv = SetW'($urandom_range(0, int'(MvMin) - 1));
            else if (pick == 1) set_mv = SetW'($urandom);
            else set_mv = SetW'($urandom_range(int'(MvMin), int'(MvMax)));
            tgt = (set_mv > MvMax) ? int'(MvMax) : int'(set_mv);
            send_item(KIND_SET, m, set_mv, MeasW'($urandom), 1'($urandom));
            done_items++;
            sender_gap();
            repeat ($urandom_range(1, 24)) begin
               pick = $urandom_range(0, 19);
               tick_m = (pick == 19) ? ~m : m;
               if (pick < 14) begin
                  meas = tgt - 40 + $urandom_range(0, int'(sb.band_mv) + 80);
                  if (meas < 0) meas = 0;
                  if (meas > 32767) meas = 32767;
               end else if (pick < 17) begin
                  meas = $urandom_range(0, 32767);
               end else begin
                  meas = $urandom_range(0, 1) ? 32767 : 0;
               end
               send_item(KIND_TICK, tick_m, SetW'($urandom), MeasW'(meas),
                         ($urandom_range(0, 6) != 0));
               done_items++;
               sender_gap();
            end
         end
      end
      wait_all_results();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed pass at reset register values (band 30, delay 3)
      send_item(KIND_TICK, 1'b0, 16'd0, 15'd0, 1'b1);         // tick while off
      send_item(KIND_SET, 1'b0, 16'd0, 15'd0, 1'b0);          // switch off
      send_item(KIND_SET, 1'b0, 16'd1219, 15'd0, 1'b1);       // just below on
      send_item(KIND_SET, 1'b0, 16'hFFFF, 15'h7FFF, 1'b1);    // clamp to max
      repeat (3) send_item(KIND_TICK, 1'b0, 16'd0, 15'd0, 1'b1);
      send_item(KIND_TICK, 1'b0, 16'd0, 15'd0, 1'b1);         // code at top limit
      send_item(KIND_TICK, 1'b0, 16'd0, 15'h7FFF, 1'b1);      // step down
      send_item(KIND_TICK, 1'b0, 16'd0, 15'h7FFF, 1'b0);      // rejected write
      send_item(KIND_TICK, 1'b0, 16'd0, 15'd4020, 1'b1);      // on target
      send_item(KIND_TICK, 1'b0, 16'd0, 15'd4050, 1'b1);      // top of band
      send_item(KIND_TICK, 1'b0, 16'd0, 15'd4051, 1'b1);      // just above band
      send_item(KIND_SET, 1'b0, 16'd1220, 15'd0, 1'b1);       // lowest target
      send_item(KIND_TICK, 1'b0, 16'd0, 15'h7FFF, 1'b1);      // code at bottom limit
      send_item(KIND_TICK, 1'b0, 16'd0, 15'd0, 1'b1);
      send_item(KIND_TICK, 1'b0, 16'd0, 15'd1219, 1'b1);
      send_item(KIND_SET, 1'b1, 16'd2620, 15'd0, 1'b1);       // mid scale
      repeat (3) send_item(KIND_TICK, 1'b1, 16'd0, 15'd0, 1'b1);
      send_item(KIND_TICK, 1'b1, 16'd0, 15'd0, 1'b1);         // crosses DAC midpoint
      send_item(KIND_TICK, 1'b1, 16'd0, 15'd0, 1'b1);
      send_item(KIND_SET, 1'b1, 16'd1000, 15'd0, 1'b1);       // enable drops
      send_item(KIND_TICK, 1'b1, 16'd0, 15'd2620, 1'b1);
      wait_all_results();

      run_trim_phase(260);

      configure('0, '0);
      run_trim_phase(260);

      configure('1, '1);
      hold_rsp = 1'b1;
      run_trim_phase(260);

      configure(BandW'($urandom), DelayW'($urandom));
      run_trim_phase(130);
      run_trim_phase(130);

      configure(BandReset, 4'd1);
      run_trim_phase(260);

      calm = 1'b1;
      configure(BandW'($urandom), DelayW'($urandom));
      run_trim_phase(260);

      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
